### rtl/core/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The antecedent holds in a cycle, so the consequent holds in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The antecedent holds in a cycle, so the consequent holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/dvrt_pkg.sv
// ----------------------------------------------------------------------------
// dvrt_pkg
// Types and constants shared by the distance-vector route table modules.
// ----------------------------------------------------------------------------
package dvrt_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 64;
    localparam int NUM_PORTS           = 8;

    localparam int ADDR_W   = 32;
    localparam int PORT_W   = 3;
    localparam int DIST_W   = 8;
    localparam int STATUS_W = 3;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    typedef enum logic [STATUS_W-1:0] {
        ST_IGNORED  = 3'd0,
        ST_ADDED    = 3'd1,
        ST_IMPROVED = 3'd2,
        ST_FULL     = 3'd3,
        ST_LOCAL    = 3'd4,
        ST_FORWARD  = 3'd5,
        ST_NOROUTE  = 3'd6
    } dvrt_status_t;

    typedef struct packed {
        logic signed [ADDR_W-1:0] addr;
        logic [PORT_W-1:0]        port;
        logic [DIST_W-1:0]        hop_dist;
    } dvrt_entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic finish;
        logic push;
    } dvrt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic done;
        logic out_full;
    } dvrt_sts_t;

endpackage

### rtl/core/dvrt_ctrl.sv
// ----------------------------------------------------------------------------
// dvrt_ctrl
// Sequencer for one item: accept, search the table, resolve, hand over.
// ----------------------------------------------------------------------------
module dvrt_ctrl
    import dvrt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  dvrt_sts_t sts,
    output dvrt_cmd_t cmd
);

    typedef enum logic [1:0] {
        IDLE,
        SCAN,
        PUSH
    } state_t;

    state_t state_reg;
    logic   s_tready_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= IDLE;
            s_tready_reg <= 1'b1;
        end
        else
        begin
            case (state_reg)
                IDLE:
                begin
                    if (s_tvalid && s_tready_reg)
                    begin
                        state_reg    <= SCAN;
                        s_tready_reg <= 1'b0;
                    end
                end
                SCAN:
                begin
                    if (sts.done)
                    begin
                        state_reg <= PUSH;
                    end
                end
                PUSH:
                begin
                    if (!sts.out_full)
                    begin
                        state_reg    <= IDLE;
                        s_tready_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg    <= IDLE;
                    s_tready_reg <= 1'b1;
                end
            endcase
        end
    end

    assign s_tready = s_tready_reg;

    always_comb
    begin
        cmd.load   = (state_reg == IDLE) && s_tvalid && s_tready_reg;
        cmd.step   = (state_reg == SCAN) && !sts.done;
        cmd.finish = (state_reg == SCAN) && sts.done;
        cmd.push   = (state_reg == PUSH) && !sts.out_full;
    end

endmodule

### rtl/core/dvrt_datapath.sv
// ----------------------------------------------------------------------------
// dvrt_datapath
// Item registers, route memory with fill count, search pipeline, result
// resolution and the output register.
// ----------------------------------------------------------------------------
module dvrt_datapath
    import dvrt_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic signed [ADDR_W-1:0]  cfg_wdata,
    input  logic [47:0]               s_tdata,
    input  logic [0:0]                s_tuser,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [15:0]               m_tdata,
    output logic [STATUS_W-1:0]       m_tuser,
    input  dvrt_cmd_t                 cmd,
    output dvrt_sts_t                 sts
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = $clog2(TABLE_DEPTH);

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_DEPTH);

    // Entries below the fill count are valid; the rest are never read.
    dvrt_entry_t mem [TABLE_DEPTH];

    logic signed [ADDR_W-1:0] local_addr_reg;
    logic [CNT_W-1:0]         used_count_reg;

    logic                     item_kind_reg;
    logic [PORT_W-1:0]        item_port_reg;
    logic signed [ADDR_W-1:0] item_addr_reg;
    logic [DIST_W-1:0]        item_hops_reg;

    logic [CNT_W-1:0]         scan_idx_reg;
    logic                     rd_pend_reg;
    logic [IDX_W-1:0]         rd_idx_reg;
    dvrt_entry_t              rd_entry_reg;

    dvrt_status_t             res_status_reg;
    logic [PORT_W-1:0]        res_port_reg;
    logic [DIST_W-1:0]        res_dist_reg;

    logic                     m_tvalid_reg;
    dvrt_status_t             out_status_reg;
    logic [PORT_W-1:0]        out_port_reg;
    logic [DIST_W-1:0]        out_dist_reg;

    logic                     is_local;
    logic                     port_bad;
    logic                     skip;
    logic                     hit_now;
    logic                     issue;
    logic [DIST_W-1:0]        new_dist;

    dvrt_status_t             res_status_next;
    logic [PORT_W-1:0]        res_port_next;
    logic [DIST_W-1:0]        res_dist_next;
    logic                     mem_we;
    logic [IDX_W-1:0]         mem_waddr;
    logic                     used_inc;

    always_comb
    begin
        is_local = (item_addr_reg == local_addr_reg);
        port_bad = (32'(item_port_reg) >= 32'(NUM_PORTS));
        skip     = is_local || (!item_kind_reg && port_bad);
        hit_now  = rd_pend_reg && (rd_entry_reg.addr == item_addr_reg);
        issue    = (scan_idx_reg < used_count_reg);
        new_dist = (item_hops_reg == DIST_MAX) ? DIST_MAX : item_hops_reg + 1'b1;
    end

    assign sts.done     = skip || hit_now || (!rd_pend_reg && !issue);
    assign sts.out_full = m_tvalid_reg && !m_tready;

    always_comb
    begin
        res_status_next = ST_IGNORED;
        res_port_next   = '0;
        res_dist_next   = '0;
        mem_we          = 1'b0;
        mem_waddr       = used_count_reg[IDX_W-1:0];
        used_inc        = 1'b0;
        if (is_local)
        begin
            res_status_next = item_kind_reg ? ST_LOCAL : ST_IGNORED;
        end
        else if (item_kind_reg)
        begin
            if (hit_now)
            begin
                res_status_next = ST_FORWARD;
                res_port_next   = rd_entry_reg.port;
                res_dist_next   = rd_entry_reg.hop_dist;
            end
            else
            begin
                res_status_next = ST_NOROUTE;
            end
        end
        else if (port_bad)
        begin
            res_status_next = ST_IGNORED;
        end
        else if (!hit_now)
        begin
            if (used_count_reg == CNT_FULL)
            begin
                res_status_next = ST_FULL;
            end
            else
            begin
                res_status_next = ST_ADDED;
                res_port_next   = item_port_reg;
                res_dist_next   = new_dist;
                mem_we          = 1'b1;
                used_inc        = 1'b1;
            end
        end
        else if (rd_entry_reg.hop_dist > new_dist)
        begin
            res_status_next = ST_IMPROVED;
            res_port_next   = item_port_reg;
            res_dist_next   = new_dist;
            mem_we          = 1'b1;
            mem_waddr       = rd_idx_reg;
        end
        else
        begin
            res_status_next = ST_IGNORED;
            res_port_next   = rd_entry_reg.port;
            res_dist_next   = rd_entry_reg.hop_dist;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_addr_reg <= '0;
            used_count_reg <= '0;
            scan_idx_reg   <= '0;
            rd_pend_reg    <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                local_addr_reg <= cfg_wdata;
            end
            if (cmd.load)
            begin
                scan_idx_reg <= '0;
                rd_pend_reg  <= 1'b0;
            end
            else if (cmd.step)
            begin
                rd_pend_reg <= issue;
                if (issue)
                begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                end
            end
            else
            begin
                rd_pend_reg <= 1'b0;
            end
            if (cmd.finish && mem_we && used_inc)
            begin
                used_count_reg <= used_count_reg + 1'b1;
            end
            if (cmd.push)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers and the route memory.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_kind_reg <= s_tuser[0];
            item_port_reg <= s_tdata[2:0];
            item_addr_reg <= s_tdata[34:3];
            item_hops_reg <= s_tdata[42:35];
        end
        if (cmd.step && issue)
        begin
            rd_entry_reg <= mem[scan_idx_reg[IDX_W-1:0]];
            rd_idx_reg   <= scan_idx_reg[IDX_W-1:0];
        end
        if (cmd.finish)
        begin
            res_status_reg <= res_status_next;
            res_port_reg   <= res_port_next;
            res_dist_reg   <= res_dist_next;
            if (mem_we)
            begin
                mem[mem_waddr] <= '{addr: item_addr_reg, port: item_port_reg,
                                    hop_dist: new_dist};
            end
        end
        if (cmd.push)
        begin
            out_status_reg <= res_status_reg;
            out_port_reg   <= res_port_reg;
            out_dist_reg   <= res_dist_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {5'b0, out_dist_reg, out_port_reg};

endmodule

### rtl/core/distance_vector_route_table_unit.sv
// ----------------------------------------------------------------------------
// distance_vector_route_table_unit
// Distance-vector route table of one router: learns routes from neighbour
// advertisements and answers forwarding lookups.
// ----------------------------------------------------------------------------
// Usage. Items arrive on the s_ stream; s_tuser says whether an item is an
// advertisement (0) or a lookup (1). Every item gives exactly one result on
// the m_ stream, with the status code in m_tuser. The router's own address
// is written through cfg_we/cfg_wdata while the block is idle.
// Timing. The table is searched one stored entry per cycle through the
// single port of the route memory, up to the match, or through all stored
// routes on a miss, before the result is resolved. The block takes no new
// item until the result of the last one has moved into the output register.
// An item for the local address, or an advertisement from a port out of
// range, skips the search.
// Reset. rst_n clears the fill count, so the table is empty at once with no
// clearing pass, and sets the local address to zero.
// Stalls. The result sits in an output register; while it waits for
// m_tready the block still accepts and works on the next item, and holds
// that item's result until the output register is free.
// ----------------------------------------------------------------------------
module distance_vector_route_table_unit
    import dvrt_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    // Configuration: local address.
    input  logic                     cfg_we,
    input  logic signed [ADDR_W-1:0] cfg_wdata,
    // Input items.
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [47:0]              s_tdata,   // port[2:0], dest_addr[34:3], hops[42:35]
    input  logic [0:0]               s_tuser,   // kind[0]
    // Results.
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [15:0]              m_tdata,   // out_port[2:0], distance[10:3]
    output logic [STATUS_W-1:0]      m_tuser    // status[2:0]
);

    dvrt_cmd_t cmd;
    dvrt_sts_t sts;

    // The controller steps through accept, search and hand-over.
    dvrt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds the table, the search pipeline and the result.
    dvrt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

### rtl/core/dvrt_checker.sv
// ----------------------------------------------------------------------------
// dvrt_checker
// Port-level checks for the route table, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dvrt_checker
    import dvrt_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [15:0]         m_tdata,
    input logic [STATUS_W-1:0] m_tuser,
    input logic                m_tvalid,
    input logic                m_tready
);

    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    `ASSERT_NEXT(a_one_item, clk, rst_n, s_tvalid && s_tready, !s_tready,
        "second item accepted while one is at work")

    `ASSERT_SAME(a_route_dist, clk, rst_n,
        m_tvalid && (m_tuser == ST_ADDED || m_tuser == ST_IMPROVED || m_tuser == ST_FORWARD),
        m_tdata[10:3] != 8'd0, "learnt route with zero distance")

    `ASSERT_SAME(a_empty_res, clk, rst_n,
        m_tvalid && (m_tuser == ST_LOCAL || m_tuser == ST_NOROUTE || m_tuser == ST_FULL),
        m_tdata == 16'd0, "result without a route carries data")

endmodule

bind distance_vector_route_table_unit dvrt_checker u_dvrt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

### tb/tb_distance_vector_route_table_unit.sv
// ----------------------------------------------------------------------------
// tb_distance_vector_route_table_unit
// Self-checking bench for the route table: a directed table of items and
// local-address writes, then random advertisements and lookups over a pool
// of addresses, each result compared with a behavioural route table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_distance_vector_route_table_unit;

    import dvrt_pkg::*;

    localparam int TABLE_DEPTH = DEFAULT_TABLE_DEPTH;
    localparam int POOL_SIZE   = 96;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 175;
    // Longest search plus the output register, with some margin.
    localparam int DRAIN_CYCLES = TABLE_DEPTH + 40;

    // One expected or observed result: status, next-hop port, distance.
    typedef struct packed {
        dvrt_status_t      status;
        logic [PORT_W-1:0] port;
        logic [DIST_W-1:0] hop_dist;
    } route_result_t;

    // One row of the directed table. A row is either a write of the local
    // address (addr holds the value) or an item; the result of an item is
    // typed in where it is plain, otherwise it comes from the route model.
    typedef struct {
        bit                is_cfg;
        bit                kind;
        logic [PORT_W-1:0] port;
        logic [ADDR_W-1:0] addr;
        logic [DIST_W-1:0] hops;
        bit                typed;
        route_result_t     res;
    } route_row_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [ADDR_W-1:0] cfg_wdata = '0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [47:0]       s_tdata   = '0;
    logic [0:0]        s_tuser   = '0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [15:0]       m_tdata;
    logic [STATUS_W-1:0] m_tuser;

    // Behavioural copy of the route table and its register.
    logic              rt_valid [TABLE_DEPTH];
    logic [ADDR_W-1:0] rt_addr  [TABLE_DEPTH];
    logic [PORT_W-1:0] rt_port  [TABLE_DEPTH];
    logic [DIST_W-1:0] rt_dist  [TABLE_DEPTH];
    int                rt_fill;
    logic [ADDR_W-1:0] rt_local;

    route_result_t     pending_results [$];
    logic [ADDR_W-1:0] addr_pool [POOL_SIZE];
    route_row_t        dir_rows [19];
    int                fault_count  = 0;
    int                burst_left   = 0;
    int unsigned       cycle_count  = 0;
    int                rx_mode      = 0;

    distance_vector_route_table_unit #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // 10 ns clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Works out the result of one item and updates the route table copy, in
    // the same way as the block: the local address wins over everything, a
    // lookup reports the stored route, and an advertisement adds an unknown
    // destination or replaces a known one only when strictly shorter.
    task automatic route_predict(input logic kind, input logic [PORT_W-1:0] port,
                                 input logic [ADDR_W-1:0] addr,
                                 input logic [DIST_W-1:0] hops,
                                 output route_result_t res);
        int                slot;
        logic [DIST_W-1:0] new_dist;
        res.status   = ST_IGNORED;
        res.port     = '0;
        res.hop_dist = '0;
        slot         = -1;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (slot < 0 && rt_valid[i] && rt_addr[i] == addr)
                slot = i;
        end
        // The hop count through this neighbour, held at the ceiling.
        new_dist = (hops == DIST_MAX) ? DIST_MAX : hops + 1'b1;
        if (addr == rt_local)
        begin
            res.status = kind ? ST_LOCAL : ST_IGNORED;
        end
        else if (kind)
        begin
            if (slot < 0)
                res.status = ST_NOROUTE;
            else
            begin
                res.status   = ST_FORWARD;
                res.port     = rt_port[slot];
                res.hop_dist = rt_dist[slot];
            end
        end
        else if (int'(port) >= NUM_PORTS)
        begin
            res.status = ST_IGNORED;
        end
        else if (slot < 0)
        begin
            // Entries are never removed, so the fill count is the free slot.
            if (rt_fill >= TABLE_DEPTH)
                res.status = ST_FULL;
            else
            begin
                rt_valid[rt_fill] = 1'b1;
                rt_addr[rt_fill]  = addr;
                rt_port[rt_fill]  = port;
                rt_dist[rt_fill]  = new_dist;
                rt_fill++;
                res.status   = ST_ADDED;
                res.port     = port;
                res.hop_dist = new_dist;
            end
        end
        else if (rt_dist[slot] > new_dist)
        begin
            rt_dist[slot] = new_dist;
            rt_port[slot] = port;
            res.status    = ST_IMPROVED;
            res.port      = port;
            res.hop_dist  = new_dist;
        end
        else
        begin
            // Not shorter: the stored route is reported unchanged.
            res.port     = rt_port[slot];
            res.hop_dist = rt_dist[slot];
        end
    endtask

    // Offers one item on the input stream. The sender runs in bursts; at the
    // start of each burst it may drop tvalid for a random gap. tvalid stays
    // high across consecutive items of a burst.
    task automatic send_item(input logic kind, input logic [PORT_W-1:0] port,
                             input logic [ADDR_W-1:0] addr,
                             input logic [DIST_W-1:0] hops,
                             input bit typed, input route_result_t typed_res);
        route_result_t res;
        int            gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 40);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, hops, addr, port};
        s_tuser  <= kind;
        do
            @(posedge clk);
        while (!s_tready);
        route_predict(kind, port, addr, hops, res);
        pending_results.insert(pending_results.size(), typed ? typed_res : res);
    endtask

    // Writes the local address once every outstanding result has come back.
    // Each item gives exactly one result, so the block is idle by then.
    task automatic set_local_address(input logic [ADDR_W-1:0] value);
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        rt_local = value;
    endtask

    // Random address: mostly from the pool so that lookups hit and routes
    // get improved, sometimes the local address, sometimes anything at all.
    function automatic logic [ADDR_W-1:0] pick_addr();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 15)
            return addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        else if (sel < 17)
            return rt_local;
        else
            return $urandom;
    endfunction

    // Hop counts lean towards small values and the ceiling.
    function automatic logic [DIST_W-1:0] pick_hops();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 3)
            return DIST_W'($urandom_range(0, 7));
        else if (sel == 3)
            return DIST_MAX;
        else if (sel == 4)
            return DIST_MAX - 1'b1;
        else
            return DIST_W'($urandom_range(0, 255));
    endfunction

    // The receiver picks a new stall pattern whenever cycle_count[6:0] is zero:
    // always ready, coin toss, one cycle in four, or mostly ready.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count[6:0] == 7'd0)
            rx_mode <= $urandom_range(0, 3);
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= (cycle_count[1:0] == 2'd0);
            default: m_tready <= ($urandom_range(0, 4) != 0);
        endcase
    end

    // Result checker: every accepted result is matched against the oldest
    // expectation, field by field.
    always @(posedge clk)
    begin
        route_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                fault_count++;
                $display("%0t: unexpected result status %0d port %0d distance %0d",
                         $time, m_tuser, m_tdata[2:0], m_tdata[10:3]);
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tuser != want.status || m_tdata[2:0] != want.port ||
                    m_tdata[10:3] != want.hop_dist)
                begin
                    fault_count++;
                    $display("%0t: expected status %0d port %0d distance %0d, got %0d %0d %0d",
                             $time, want.status, want.port, want.hop_dist,
                             m_tuser, m_tdata[2:0], m_tdata[10:3]);
                end
            end
        end
    end

    initial
    begin
        logic [ADDR_W-1:0] phase_local [PHASES];
        logic              kind;

        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            rt_valid[i] = 1'b0;
            rt_addr[i]  = '0;
            rt_port[i]  = '0;
            rt_dist[i]  = '0;
        end
        rt_fill  = 0;
        rt_local = '0;

        // The pool holds the address extremes and random addresses. With
        // more pool members than table slots the table fills up and later
        // additions are dropped.
        addr_pool[0] = 32'h0000_0000;
        addr_pool[1] = 32'h7FFF_FFFF;
        addr_pool[2] = 32'h8000_0000;
        addr_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < POOL_SIZE; i++)
            addr_pool[i] = $urandom;

        // Directed rows: empty table, the local address after reset, adding
        // at both address extremes, the distance ceiling, a route that is not
        // shorter, an improvement, and lookups while the local address moves.
        dir_rows = '{
            '{0, 1, 3'd0, 32'h0000_0000, 8'd0,   1, '{ST_LOCAL,    3'd0, 8'd0}},
            '{0, 0, 3'd3, 32'h0000_0000, 8'd5,   1, '{ST_IGNORED,  3'd0, 8'd0}},
            '{0, 1, 3'd0, 32'h1234_5678, 8'd0,   1, '{ST_NOROUTE,  3'd0, 8'd0}},
            '{0, 0, 3'd7, 32'h7FFF_FFFF, 8'd0,   1, '{ST_ADDED,    3'd7, 8'd1}},
            '{0, 0, 3'd0, 32'h8000_0000, 8'd255, 1, '{ST_ADDED,    3'd0, 8'd255}},
            '{0, 0, 3'd5, 32'h8000_0000, 8'd254, 1, '{ST_IGNORED,  3'd0, 8'd255}},
            '{0, 0, 3'd2, 32'h8000_0000, 8'd253, 1, '{ST_IMPROVED, 3'd2, 8'd254}},
            '{0, 1, 3'd7, 32'h8000_0000, 8'd255, 0, '{ST_IGNORED,  3'd0, 8'd0}},
            '{0, 0, 3'd1, 32'h7FFF_FFFF, 8'd3,   0, '{ST_IGNORED,  3'd0, 8'd0}},
            '{0, 1, 3'd0, 32'h7FFF_FFFF, 8'd0,   0, '{ST_IGNORED,  3'd0, 8'd0}},
            '{0, 0, 3'd4, 32'hFFFF_FFFF, 8'd0,   1, '{ST_ADDED,    3'd4, 8'd1}},
            '{1, 0, 3'd0, 32'h7FFF_FFFF, 8'd0,   0, '{ST_IGNORED,  3'd0, 8'd0}},
            '{0, 1, 3'd0, 32'h7FFF_FFFF, 8'd0,   1, '{ST_LOCAL,    3'd0, 8'd0}},
            '{0, 0, 3'd6, 32'h7FFF_FFFF, 8'd0,   1, '{ST_IGNORED,  3'd0, 8'd0}},
            '{0, 1, 3'd0, 32'h0000_0000, 8'd0,   1, '{ST_NOROUTE,  3'd0, 8'd0}},
            '{1, 0, 3'd0, 32'h8000_0000, 8'd0,   0, '{ST_IGNORED,  3'd0, 8'd0}},
            '{0, 1, 3'd0, 32'h8000_0000, 8'd0,   1, '{ST_LOCAL,    3'd0, 8'd0}},
            '{0, 1, 3'd0, 32'h7FFF_FFFF, 8'd0,   0, '{ST_IGNORED,  3'd0, 8'd0}},
            '{1, 0, 3'd0, 32'h0000_0000, 8'd0,   0, '{ST_IGNORED,  3'd0, 8'd0}}
        };

        // Local addresses of the random phases: a pool member that may be in
        // the table, the extremes, a random value and zero.
        phase_local = '{addr_pool[$urandom_range(4, POOL_SIZE - 1)], 32'h8000_0000,
                        $urandom, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[r])
        begin
            if (dir_rows[r].is_cfg)
                set_local_address(dir_rows[r].addr);
            else
                send_item(dir_rows[r].kind, dir_rows[r].port, dir_rows[r].addr,
                          dir_rows[r].hops, dir_rows[r].typed, dir_rows[r].res);
        end

        // Random phases, each under its own local address.
        for (int p = 0; p < PHASES; p++)
        begin
            set_local_address(phase_local[p]);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                kind = ($urandom_range(0, 99) < 45);
                send_item(kind, PORT_W'($urandom_range(0, 7)), pick_addr(), pick_hops(),
                          1'b0, '0);
            end
        end

        // Drain: every result must arrive, then nothing more may follow.
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fault_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog, several times the slowest expected run.
    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
